FILE: rtl/p2prgb_pkg.sv
// Shared types and constants for the planar-to-packed RGB line buffer.
// No dependencies; every other rtl file refers to it by scoped names.
package p2prgb_pkg;

    localparam int MAX_WIDTH_DEF = 4096;   // default pixels per line limit
    localparam int BYTE_W        = 8;
    localparam int RAW_W         = 13;     // line width register width
    localparam int CFG_IDX_W     = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 1'b1;

    // register reset values
    localparam logic             COLOR_MODE_RST = 1'b1;
    localparam logic [RAW_W-1:0] LINE_WIDTH_RST = 13'd1024;

    // word kinds on the input side
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    // result queue depth
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    // status of one item, travels from the control unit to the output stage
    typedef struct packed {
        logic accepted;
        logic out_valid;
        logic eol;
    } t_meta;

    // one result word as queued for the output
    typedef struct packed {
        logic              accepted;
        logic              out_valid;
        logic              eol;
        logic [BYTE_W-1:0] data;
    } t_result;

endpackage

FILE: rtl/p2prgb_mem.sv
// Line store RAM: one write port, one read port, registered read data.
// Depends on p2prgb_pkg for the byte width.
module p2prgb_mem #(
    parameter int DEPTH = 24576,
    parameter int AW    = 15
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [p2prgb_pkg::BYTE_W-1:0] i_wr_data,
    input  logic                          i_rd_en,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic [p2prgb_pkg::BYTE_W-1:0] o_rd_data
);

    logic [p2prgb_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [p2prgb_pkg::BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/p2prgb_ctrl.sv
// Fill/drain control: config registers, ping-pong line state, RAM addresses.
// Depends on p2prgb_pkg (codes, t_meta).
module p2prgb_ctrl #(
    parameter int MAX_WIDTH = p2prgb_pkg::MAX_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [p2prgb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [p2prgb_pkg::RAW_W-1:0]     i_cfg_data,
    output logic                             o_cfg_hold,
    input  logic                             i_item_valid,
    input  logic                             i_op,
    input  logic [p2prgb_pkg::BYTE_W-1:0]    i_byte,
    output logic                             o_wr_en,
    output logic [$clog2(6*MAX_WIDTH)-1:0]   o_wr_addr,
    output logic [p2prgb_pkg::BYTE_W-1:0]    o_wr_data,
    output logic                             o_rd_en,
    output logic [$clog2(6*MAX_WIDTH)-1:0]   o_rd_addr,
    output p2prgb_pkg::t_meta                o_meta
);

    localparam int STORE = 3 * MAX_WIDTH;
    localparam int AW    = $clog2(2 * STORE);
    localparam int PW    = $clog2(STORE);
    localparam int CW    = $clog2(STORE + 1);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CMPW  = (WW > p2prgb_pkg::RAW_W) ? WW : p2prgb_pkg::RAW_W;
    localparam int SW    = $clog2(5 * MAX_WIDTH);

    localparam logic [1:0] PLANE_R = 2'd0;
    localparam logic [1:0] PLANE_G = 2'd1;
    localparam logic [1:0] PLANE_B = 2'd2;

    // config and derived line geometry
    logic                         r_color_mode;
    logic [p2prgb_pkg::RAW_W-1:0] r_line_width;
    logic                         r_hold;
    logic [WW-1:0]                r_w,   n_w;
    logic [CW-1:0]                r_len, n_len;
    logic [CMPW-1:0]              raw_ext;

    // line state
    logic [PW-1:0] r_fill_count,  n_fill_count;
    logic          r_fill_sel,    n_fill_sel;
    logic [1:0]    r_line_ready,  n_line_ready;
    logic          r_drain_sel,   n_drain_sel;
    logic [PW-1:0] r_drain_pixel, n_drain_pixel;
    logic [1:0]    r_drain_plane, n_drain_plane;
    logic [PW-1:0] r_drain_count, n_drain_count;

    logic [CW-1:0] fill_next;
    logic [CW-1:0] drain_next;
    logic [SW-1:0] base;
    logic [SW-1:0] off_raw;
    logic [SW-1:0] off_wrap;
    logic          push_ok;
    logic          pull_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= p2prgb_pkg::COLOR_MODE_RST;
            r_line_width <= p2prgb_pkg::LINE_WIDTH_RST;
            r_hold       <= 1'b1;
        end else begin
            r_hold <= i_cfg_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    p2prgb_pkg::CFG_COLOR_MODE: r_color_mode <= i_cfg_data[0];
                    p2prgb_pkg::CFG_LINE_WIDTH: r_line_width <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // clamp width and form line length; registered behind the config registers
    always_comb begin
        raw_ext = CMPW'(r_line_width);
        if (raw_ext == '0) begin
            n_w = WW'(1);
        end else if (raw_ext > CMPW'(MAX_WIDTH)) begin
            n_w = WW'(MAX_WIDTH);
        end else begin
            n_w = WW'(raw_ext);
        end
        n_len = r_color_mode ? (CW'(n_w) + (CW'(n_w) << 1)) : CW'(n_w);
    end

    always_ff @(posedge i_clk) begin
        r_w   <= n_w;
        r_len <= n_len;
    end

    assign o_cfg_hold = r_hold;

    // plane base plus pixel, wrapped inside one store
    always_comb begin
        case (r_drain_plane)
            PLANE_G: base = SW'(r_w);
            PLANE_B: base = SW'({r_w, 1'b0});
            default: base = '0;
        endcase
        if (!r_color_mode) begin
            base = '0;
        end
        off_raw  = base + SW'(r_drain_pixel);
        off_wrap = (off_raw >= SW'(STORE)) ? (off_raw - SW'(STORE)) : off_raw;
    end

    always_comb begin
        n_fill_count  = r_fill_count;
        n_fill_sel    = r_fill_sel;
        n_line_ready  = r_line_ready;
        n_drain_sel   = r_drain_sel;
        n_drain_pixel = r_drain_pixel;
        n_drain_plane = r_drain_plane;
        n_drain_count = r_drain_count;
        fill_next     = CW'(r_fill_count) + CW'(1);
        drain_next    = CW'(r_drain_count) + CW'(1);
        push_ok       = i_item_valid && (i_op == p2prgb_pkg::OP_PUSH)
                        && !r_line_ready[r_fill_sel];
        pull_ok       = i_item_valid && (i_op == p2prgb_pkg::OP_PULL)
                        && r_line_ready[r_drain_sel];
        o_meta        = '0;

        o_wr_en   = push_ok;
        o_wr_data = i_byte;
        o_wr_addr = r_fill_sel ? (AW'(r_fill_count) + AW'(STORE)) : AW'(r_fill_count);
        o_rd_en   = pull_ok;
        o_rd_addr = r_drain_sel ? (AW'(off_wrap) + AW'(STORE)) : AW'(off_wrap);

        if (push_ok) begin
            o_meta.accepted = 1'b1;
            if (fill_next >= r_len) begin
                n_line_ready[r_fill_sel] = 1'b1;
                n_fill_count             = '0;
                n_fill_sel               = ~r_fill_sel;
            end else begin
                n_fill_count = PW'(fill_next);
            end
        end

        if (pull_ok) begin
            o_meta.out_valid = 1'b1;
            if (drain_next >= r_len) begin
                o_meta.eol                = 1'b1;
                n_line_ready[r_drain_sel] = 1'b0;
                n_drain_sel               = ~r_drain_sel;
                n_drain_count             = '0;
                n_drain_pixel             = '0;
                n_drain_plane             = PLANE_R;
            end else begin
                n_drain_count = PW'(drain_next);
                if (r_color_mode) begin
                    if (r_drain_plane >= PLANE_B) begin
                        n_drain_plane = PLANE_R;
                        n_drain_pixel = r_drain_pixel + PW'(1);
                    end else begin
                        n_drain_plane = r_drain_plane + 2'd1;
                    end
                end else begin
                    n_drain_pixel = r_drain_pixel + PW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_count  <= '0;
            r_fill_sel    <= 1'b0;
            r_line_ready  <= '0;
            r_drain_sel   <= 1'b0;
            r_drain_pixel <= '0;
            r_drain_plane <= PLANE_R;
            r_drain_count <= '0;
        end else begin
            r_fill_count  <= n_fill_count;
            r_fill_sel    <= n_fill_sel;
            r_line_ready  <= n_line_ready;
            r_drain_sel   <= n_drain_sel;
            r_drain_pixel <= n_drain_pixel;
            r_drain_plane <= n_drain_plane;
            r_drain_count <= n_drain_count;
        end
    end

    // a completed line is flagged ready on the next cycle
    a_line_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_ok && (fill_next >= r_len)) |=> r_line_ready[$past(r_fill_sel)])
        else $error("completed line not marked ready");

    // never a fill into a store that is still being drained
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> !(r_line_ready[r_fill_sel]) && !(o_rd_en))
        else $error("write into a ready line store");

    // drained line is released and the other store selected
    a_drain_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_meta.eol |=> (r_drain_sel != $past(r_drain_sel)) && (r_drain_count == '0))
        else $error("end of line did not release the store");

endmodule

FILE: rtl/p2prgb_outq.sv
// Small result queue decoupling the RAM read stage from the output word.
// Depends on p2prgb_pkg (t_result, queue depth).
module p2prgb_outq (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  p2prgb_pkg::t_result                i_data,
    output logic [p2prgb_pkg::OUTQ_CW-1:0]     o_count,
    output logic                               o_valid,
    input  logic                               i_ready,
    output p2prgb_pkg::t_result                o_data
);

    p2prgb_pkg::t_result                 r_q [p2prgb_pkg::OUTQ_DEPTH];
    logic [p2prgb_pkg::OUTQ_PW-1:0]      r_head, n_head;
    logic [p2prgb_pkg::OUTQ_PW-1:0]      r_tail, n_tail;
    logic [p2prgb_pkg::OUTQ_CW-1:0]      r_count, n_count;
    logic                                pop;

    assign pop     = (r_count != '0) && i_ready;
    assign o_valid = (r_count != '0);
    assign o_data  = r_q[r_head];
    assign o_count = r_count;

    always_comb begin
        n_head  = pop ? (r_head + p2prgb_pkg::OUTQ_PW'(1)) : r_head;
        n_tail  = i_push ? (r_tail + p2prgb_pkg::OUTQ_PW'(1)) : r_tail;
        n_count = r_count + p2prgb_pkg::OUTQ_CW'(i_push) - p2prgb_pkg::OUTQ_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_tail] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != p2prgb_pkg::OUTQ_CW'(p2prgb_pkg::OUTQ_DEPTH)) || pop)
        else $error("result queue overflow");

endmodule

FILE: rtl/planar_to_packed_rgb_line_buffer.sv
// Top level of the planar-to-packed RGB line buffer: control, line RAM, result queue.
// Depends on p2prgb_pkg, p2prgb_ctrl, p2prgb_mem, p2prgb_outq.
//
// channel | direction | handshake           | payload
// --------+-----------+---------------------+------------------------------------------
// s       | in        | i_s_tvalid/o_s_tready | tdata: in_byte; tuser: operation
// m       | out       | o_m_tvalid/i_m_tready | tdata: out_byte; tuser: accepted,
//         |           |                     |   out_valid; tlast: end_of_line
// cfg     | in        | i_cfg_valid/o_cfg_ready | index (0 colour mode, 1 line width), data
//
// One word in per cycle while o_s_tready is high, one result word out per input word;
// each result passes the control and RAM read stage, then the result queue.
// Throughput is set by the single-port-each-way line RAM: one access per word.
// Reset is synchronous, active low; no clearing pass, RAM contents are left as is.
// o_s_tready drops after reset and after each config write while the line length
// is recomputed, and when the result queue plus the read stage would exceed four
// words; a stalled output therefore backs up within four words.
module planar_to_packed_rgb_line_buffer #(
    parameter int MAX_WIDTH = p2prgb_pkg::MAX_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [p2prgb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [p2prgb_pkg::RAW_W-1:0]     i_cfg_data,
    // input words
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [p2prgb_pkg::BYTE_W-1:0]    i_s_tdata,   // [7:0] in_byte
    input  logic                             i_s_tuser,   // [0] operation
    // result words
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [p2prgb_pkg::BYTE_W-1:0]    o_m_tdata,   // [7:0] out_byte
    output logic [1:0]                       o_m_tuser,   // [0] accepted, [1] out_valid
    output logic                             o_m_tlast    // end_of_line
);

    localparam int STORE = 3 * MAX_WIDTH;
    localparam int DEPTH = 2 * STORE;
    localparam int AW    = $clog2(DEPTH);

    logic                                 cfg_hold;
    logic                                 item_acc;
    logic                                 wr_en;
    logic [AW-1:0]                        wr_addr;
    logic [p2prgb_pkg::BYTE_W-1:0]        wr_data;
    logic                                 rd_en;
    logic [AW-1:0]                        rd_addr;
    logic [p2prgb_pkg::BYTE_W-1:0]        rd_data;
    p2prgb_pkg::t_meta                    meta;

    // read stage: status waits here for the registered RAM data
    logic                                 r_s1_valid;
    p2prgb_pkg::t_meta                    r_s1_meta;
    p2prgb_pkg::t_result                  s1_result;

    logic [p2prgb_pkg::OUTQ_CW-1:0]       q_count;
    logic [p2prgb_pkg::OUTQ_CW-1:0]       in_flight;
    p2prgb_pkg::t_result                  q_data;

    assign o_cfg_ready = 1'b1;

    // room check uses only registered state, so ready has no path from i_m_tready
    assign in_flight  = q_count + p2prgb_pkg::OUTQ_CW'(r_s1_valid);
    assign o_s_tready = !cfg_hold
                        && (in_flight < p2prgb_pkg::OUTQ_CW'(p2prgb_pkg::OUTQ_DEPTH));
    assign item_acc   = i_s_tvalid && o_s_tready;

    p2prgb_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_cfg_hold   (cfg_hold),
        .i_item_valid (item_acc),
        .i_op         (i_s_tuser),
        .i_byte       (i_s_tdata),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .o_meta       (meta)
    );

    p2prgb_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= item_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_meta <= meta;
    end

    // byte only meaningful on a successful pull; zero otherwise
    always_comb begin
        s1_result.accepted  = r_s1_meta.accepted;
        s1_result.out_valid = r_s1_meta.out_valid;
        s1_result.eol       = r_s1_meta.eol;
        s1_result.data      = r_s1_meta.out_valid ? rd_data : '0;
    end

    p2prgb_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (s1_result),
        .o_count (q_count),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (q_data)
    );

    assign o_m_tdata    = q_data.data;
    assign o_m_tuser[0] = q_data.accepted;
    assign o_m_tuser[1] = q_data.out_valid;
    assign o_m_tlast    = q_data.eol;

    // a result word is either a push status or a pull byte, never both
    a_kind_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("result word marked both accepted and valid");

    // end of line only ever comes with a valid byte
    a_eol_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> o_m_tuser[1])
        else $error("end of line on an empty pull");

endmodule

FILE: tb/planar_to_packed_rgb_line_buffer_tb.sv
// Self-checking bench for planar_to_packed_rgb_line_buffer: random-gap stream driver,
// checking monitor and a shadow line-buffer predictor. Depends on p2prgb_pkg and the RTL.
`timescale 1ns / 100ps

module planar_to_packed_rgb_line_buffer_tb;

    localparam int BANK_BYTES  = 3 * p2prgb_pkg::MAX_WIDTH_DEF;   // one line store
    localparam int IDLE_PCT    = 22;
    localparam int HOLD_LEN    = 400;                 // long receiver hold-off, cycles
    localparam int WIDE_PUSHES = 200;                 // part line under the widest setting

    typedef struct packed {
        logic                          op;
        logic [p2prgb_pkg::BYTE_W-1:0] payload;
    } t_scan_word;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [p2prgb_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [p2prgb_pkg::RAW_W-1:0]     i_cfg_data  = '0;
    logic                             i_s_tvalid  = 1'b0;
    logic                             o_s_tready;
    logic [p2prgb_pkg::BYTE_W-1:0]    i_s_tdata   = '0;
    logic                             i_s_tuser   = 1'b0;
    logic                             o_m_tvalid;
    logic                             i_m_tready  = 1'b0;
    logic [p2prgb_pkg::BYTE_W-1:0]    o_m_tdata;
    logic [1:0]                       o_m_tuser;
    logic                             o_m_tlast;

    planar_to_packed_rgb_line_buffer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    // stimulus words waiting for the driver, and results still owed by the block
    t_scan_word          pending_words[$];
    p2prgb_pkg::t_result predicted_results[$];
    int         errors    = 0;
    bit         steady    = 1'b0;   // both sides drop their random gaps
    int         hold_req  = 0;      // bumped to ask for a receiver hold-off
    int         hold_seen = 0;
    int         hold_left = 0;

    // shadow of the block: two line stores plus fill and drain pointers
    logic [p2prgb_pkg::BYTE_W-1:0] shadow_store [0:2*BANK_BYTES-1];
    int unsigned       fill_pos   = 0;
    bit                fill_bank  = 1'b0;
    bit [1:0]          ready_banks = 2'b00;
    bit                drain_bank = 1'b0;
    int unsigned       drain_px   = 0;
    int unsigned       drain_pl   = 0;
    int unsigned       drain_pos  = 0;
    bit                shadow_colour = p2prgb_pkg::COLOR_MODE_RST;
    logic [p2prgb_pkg::RAW_W-1:0] shadow_width = p2prgb_pkg::LINE_WIDTH_RST;

    // out-of-range widths: zero acts as one, anything above the store limit is clamped
    function automatic int unsigned clamped_width();
        if (shadow_width == 0) return 1;
        if (shadow_width > p2prgb_pkg::MAX_WIDTH_DEF) return p2prgb_pkg::MAX_WIDTH_DEF;
        return shadow_width;
    endfunction

    function automatic int unsigned line_bytes();
        return shadow_colour ? 3 * clamped_width() : clamped_width();
    endfunction

    // result of one accepted word; advances the shadow state
    function automatic p2prgb_pkg::t_result reassemble(logic op,
                                                       logic [p2prgb_pkg::BYTE_W-1:0] b);
        p2prgb_pkg::t_result r;
        int unsigned w;
        int unsigned len;
        int unsigned off;
        w   = clamped_width();
        len = line_bytes();
        r   = '0;
        if (op == p2prgb_pkg::OP_PUSH) begin
            // refused while the store being filled still holds an undrained line
            if (!ready_banks[fill_bank]) begin
                shadow_store[fill_bank * BANK_BYTES + fill_pos % BANK_BYTES] = b;
                fill_pos++;
                if (fill_pos >= len) begin
                    ready_banks[fill_bank] = 1'b1;
                    fill_pos  = 0;
                    fill_bank = ~fill_bank;
                end
                r.accepted = 1'b1;
            end
        end else if (ready_banks[drain_bank]) begin
            // colour lines come out R,G,B per pixel from plane offset plus pixel
            off = shadow_colour ? (drain_pl % 3) * w + drain_px : drain_px;
            off = off % BANK_BYTES;
            r.out_valid = 1'b1;
            r.data      = shadow_store[drain_bank * BANK_BYTES + off];
            drain_pos++;
            if (drain_pos >= len) begin
                r.eol = 1'b1;
                ready_banks[drain_bank] = 1'b0;
                drain_bank = ~drain_bank;
                drain_pos  = 0;
                drain_px   = 0;
                drain_pl   = 0;
            end else if (shadow_colour) begin
                if (drain_pl >= 2) begin
                    drain_pl = 0;
                    drain_px++;
                end else begin
                    drain_pl++;
                end
            end else begin
                drain_px++;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, int want, int got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        errors++;
    endtask

    // clock, and an initial reset held low
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // input driver: prediction happens on the accepting edge
    always @(posedge i_clk) begin : drive_words
        t_scan_word w;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                predicted_results.push_back(reassemble(i_s_tuser, i_s_tdata));
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_words.size() != 0 &&
                    (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    w = pending_words.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= w.payload;
                    i_s_tuser  <= w.op;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver hold-off counter, restarted on each request
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_LEN;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor: each word against the oldest prediction
    always @(posedge i_clk) begin : check_words
        p2prgb_pkg::t_result want;
        p2prgb_pkg::t_result got;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got = {o_m_tuser[0], o_m_tuser[1], o_m_tlast, o_m_tdata};
                if (predicted_results.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %0h",
                             $time, got);
                    errors++;
                end else begin
                    want = predicted_results.pop_front();
                    if (got.accepted !== want.accepted)
                        report_mismatch("accepted", want.accepted, got.accepted);
                    if (got.out_valid !== want.out_valid)
                        report_mismatch("out_valid", want.out_valid, got.out_valid);
                    if (got.data !== want.data)
                        report_mismatch("out_byte", want.data, got.data);
                    if (got.eol !== want.eol)
                        report_mismatch("end_of_line", want.eol, got.eol);
                end
            end
            i_m_tready <= (hold_left == 0) && (steady || $urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic queue_word(logic op, logic [p2prgb_pkg::BYTE_W-1:0] b);
        pending_words.push_back('{op: op, payload: b});
    endtask

    // sender pause: nothing queued, nothing offered, nothing owed;
    // sampled on the falling edge so the driver's updates have settled
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || i_s_tvalid || predicted_results.size() != 0);
    endtask

    // pull out every ready line so a new format never reads unwritten bytes;
    // a part-filled line is kept and finishes under the new format
    task automatic drain_ready_lines();
        wait_idle();
        while (ready_banks != 2'b00) begin
            repeat (line_bytes() - drain_pos)
                queue_word(p2prgb_pkg::OP_PULL, p2prgb_pkg::BYTE_W'($urandom));
            wait_idle();
        end
    endtask

    // both registers back to back, valid held high across the pair
    task automatic set_scan_format(bit colour, logic [p2prgb_pkg::RAW_W-1:0] width);
        logic [p2prgb_pkg::RAW_W-1:0] mode_word;
        drain_ready_lines();
        mode_word = {(p2prgb_pkg::RAW_W-1)'($urandom), colour};   // upper bits are don't-care
        i_cfg_valid <= 1'b1;
        i_cfg_index <= p2prgb_pkg::CFG_COLOR_MODE;
        i_cfg_data  <= mode_word;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_colour = mode_word[0];
        i_cfg_index <= p2prgb_pkg::CFG_LINE_WIDTH;
        i_cfg_data  <= width;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_width = width;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int push_pct;
        int n;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);

        // pulls with nothing ready, under the reset format
        queue_word(p2prgb_pkg::OP_PULL, 8'h00);
        queue_word(p2prgb_pkg::OP_PULL, 8'hFF);

        // width zero acts as one pixel: colour line of three bytes;
        // fill both stores, one refused push, then drain both and pull on empty
        set_scan_format(1'b1, 13'd0);
        queue_word(p2prgb_pkg::OP_PUSH, 8'h00);
        queue_word(p2prgb_pkg::OP_PUSH, 8'hFF);
        queue_word(p2prgb_pkg::OP_PUSH, 8'hA5);
        queue_word(p2prgb_pkg::OP_PUSH, 8'h5A);
        queue_word(p2prgb_pkg::OP_PUSH, 8'h01);
        queue_word(p2prgb_pkg::OP_PUSH, 8'h80);
        queue_word(p2prgb_pkg::OP_PUSH, 8'h7E);
        repeat (7) queue_word(p2prgb_pkg::OP_PULL, 8'h3C);

        // gray pass-through, then a format change with a line half filled
        set_scan_format(1'b0, 13'd2);
        queue_word(p2prgb_pkg::OP_PUSH, 8'h11);
        queue_word(p2prgb_pkg::OP_PUSH, 8'h22);
        queue_word(p2prgb_pkg::OP_PULL, 8'h00);
        queue_word(p2prgb_pkg::OP_PULL, 8'h00);
        queue_word(p2prgb_pkg::OP_PUSH, 8'h33);
        set_scan_format(1'b1, 13'd1);
        queue_word(p2prgb_pkg::OP_PUSH, 8'h44);
        queue_word(p2prgb_pkg::OP_PUSH, 8'h55);
        repeat (3) queue_word(p2prgb_pkg::OP_PULL, 8'hC3);

        // widest setting: register at all ones, clamped to the store limit.
        // A part line is pushed while the receiver holds off, so the block backs up;
        // it completes under the first small format below.
        set_scan_format(1'b0, 13'h1FFF);
        hold_req <= hold_req + 1;
        repeat (WIDE_PUSHES)
            queue_word(p2prgb_pkg::OP_PUSH, p2prgb_pkg::BYTE_W'($urandom));
        wait_idle();

        // random phases: small widths, mixed push/pull balance so stores both
        // overflow and run dry; part-filled lines carry over format changes;
        // one phase runs with no gaps on either side
        for (int ph = 0; ph < 6; ph++) begin
            set_scan_format(1'($urandom), p2prgb_pkg::RAW_W'($urandom_range(1, 6)));
            steady <= (ph == 3);
            push_pct = (ph % 3 == 0) ? 35 : (ph % 3 == 1) ? 50 : 65;
            n = 0;
            while (n < 105) begin
                if ($urandom_range(99) < push_pct)
                    queue_word(p2prgb_pkg::OP_PUSH, p2prgb_pkg::BYTE_W'($urandom));
                else
                    queue_word(p2prgb_pkg::OP_PULL, p2prgb_pkg::BYTE_W'($urandom));
                n++;
            end
        end

        // end of run: let everything drain, bounded
        while (pending_words.size() != 0 || i_s_tvalid) @(negedge i_clk);
        n = 0;
        while (n < 5000 && predicted_results.size() != 0) begin
            @(negedge i_clk);
            n++;
        end
        repeat (20) @(posedge i_clk);
        if (predicted_results.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, predicted_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
